/* rtl/core/sfh_pkg.sv */
// Shared types, sizes and mixing functions for the byte-stream hash block.
`timescale 1ns / 1ps

package sfh_pkg;

  localparam int unsigned LenW       = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // One unit of work handed from the front end to the key datapath.
  typedef struct packed {
    logic            start;     // first byte of a message: seed the key with the length
    logic [LenW-1:0] seed;
    logic            round;     // a full group of four bytes is ready for a mixing round
    logic [31:0]     word;      // the four bytes, first byte in bits 7..0
    logic            finish;    // last byte seen: fold the tail and emit the key
    logic            zero;      // zero-length message: emit a zero key
    logic [1:0]      tail_cnt;  // bytes left over for the tail
    logic [23:0]     tail;
  } sfh_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sfh_qstat_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // One mixing round over two little-endian unsigned 16-bit halves.
  function automatic logic [31:0] mix_round(input logic [31:0] k_in, input logic [31:0] word);
    logic [31:0] k;
    logic [31:0] t;
    k = k_in + {16'h0000, word[15:0]};
    t = ({16'h0000, word[31:16]} << 11) ^ k;
    k = (k << 16) ^ t;
    k = k + (k >> 11);
    return k;
  endfunction

  // Folds in the one-, two- or three-byte tail.
  function automatic logic [31:0] tail_mix(input logic [31:0] k_in, input logic [1:0] cnt,
                                           input logic [23:0] tail);
    logic [31:0] k;
    k = k_in;
    case (cnt)
      2'd3: begin
        k = k + {16'h0000, tail[15:0]};
        k = k ^ (k << 16);
        k = k ^ (sext8(tail[23:16]) << 18);
        k = k + (k >> 11);
      end
      2'd2: begin
        k = k + {16'h0000, tail[15:0]};
        k = k ^ (k << 11);
        k = k + (k >> 17);
      end
      2'd1: begin
        k = k + sext8(tail[7:0]);
        k = k ^ (k << 10);
        k = k + (k >> 1);
      end
      default: k = k_in;
    endcase
    return k;
  endfunction

  // The avalanche, split into three pairs of steps.
  function automatic logic [31:0] aval_a(input logic [31:0] k_in);
    logic [31:0] k;
    k = k_in ^ (k_in << 3);
    k = k + (k >> 5);
    return k;
  endfunction

  function automatic logic [31:0] aval_b(input logic [31:0] k_in);
    logic [31:0] k;
    k = k_in ^ (k_in << 4);
    k = k + (k >> 17);
    return k;
  endfunction

  function automatic logic [31:0] aval_c(input logic [31:0] k_in);
    logic [31:0] k;
    k = k_in ^ (k_in << 25);
    k = k + (k >> 6);
    return k;
  endfunction

endpackage

/* rtl/core/sfh_front.sv */
// Front end: accepts bytes, gathers groups of four and builds work items for the datapath.
`timescale 1ns / 1ps

module sfh_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            data_byte_i,
  input  logic [15:0]           message_length_i,
  input  logic                  last_byte_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  q_ready_i,
  output logic                  push_o,
  output sfh_pkg::sfh_job_t     job_o
);
  import sfh_pkg::*;

  logic        in_msg_q, in_msg_d;
  logic [1:0]  phase_q, phase_d;
  logic [23:0] held_q, held_d;

  logic        accept;
  logic        first;
  logic        zero_len;
  logic [1:0]  cur_phase;
  logic [23:0] cur_held;
  logic [1:0]  new_phase;
  logic [23:0] new_held;
  logic        do_round;

  always_comb begin
    in_ready_o = q_ready_i;
    accept     = in_valid_i && q_ready_i;
    first      = !in_msg_q;
    zero_len   = first && (message_length_i == '0);
    cur_phase  = first ? 2'd0  : phase_q;
    cur_held   = first ? 24'd0 : held_q;

    do_round  = 1'b0;
    new_phase = cur_phase + 2'd1;
    new_held  = cur_held;
    case (cur_phase)
      2'd0: new_held = {cur_held[23:8], data_byte_i};
      2'd1: new_held = {cur_held[23:16], data_byte_i, cur_held[7:0]};
      2'd2: new_held = {data_byte_i, cur_held[15:0]};
      default: begin
        do_round  = 1'b1;
        new_phase = 2'd0;
        new_held  = 24'd0;
      end
    endcase

    job_o          = '0;
    job_o.start    = first;
    job_o.seed     = message_length_i;
    job_o.round    = do_round;
    job_o.word     = {data_byte_i, cur_held};
    job_o.finish   = last_byte_i;
    job_o.tail_cnt = new_phase;
    job_o.tail     = new_held;
    push_o         = accept && (first || do_round || last_byte_i);
    if (zero_len) begin
      job_o      = '0;
      job_o.zero = 1'b1;
      push_o     = accept;
    end

    in_msg_d = in_msg_q;
    phase_d  = phase_q;
    held_d   = held_q;
    if (accept && !zero_len) begin
      if (last_byte_i) begin
        in_msg_d = 1'b0;
        phase_d  = 2'd0;
        held_d   = 24'd0;
      end else begin
        in_msg_d = 1'b1;
        phase_d  = new_phase;
        held_d   = new_held;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      phase_q  <= 2'd0;
      held_q   <= 24'd0;
    end else begin
      in_msg_q <= in_msg_d;
      phase_q  <= phase_d;
      held_q   <= held_d;
    end
  end

endmodule

/* rtl/core/sfh_queue.sv */
// Short work-item queue between the front end and the key datapath.
`timescale 1ns / 1ps

module sfh_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sfh_pkg::sfh_job_t     job_i,
  output logic                  ready_o,
  input  logic                  pop_i,
  output sfh_pkg::sfh_job_t     head_o,
  output sfh_pkg::sfh_qstat_t   stat_o
);
  import sfh_pkg::*;

  sfh_job_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_comb begin
    stat_o.full  = (cnt_q == QCntW'(QueueDepth));
    stat_o.empty = (cnt_q == '0);
    ready_o      = !stat_o.full;
    head_o       = mem_q[rd_ptr_q];
    wr_ptr_d     = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d     = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d        = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* rtl/core/sfh_back.sv */
// Key datapath: running key, mixing rounds, tail fold and pipelined avalanche.
`timescale 1ns / 1ps

module sfh_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfh_pkg::sfh_job_t     head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  output logic [31:0]           hash_key_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);
  import sfh_pkg::*;

  logic [31:0] key_q, key_d;
  logic [31:0] k_seed, k_mixed;
  logic        ends_msg;

  // Finishing pipeline: pre-tail key, tail folded, then three avalanche pairs.
  logic        fin_vld_q;
  logic [31:0] fin_k_q;
  logic [1:0]  fin_cnt_q;
  logic [23:0] fin_tail_q;
  logic        fin_adv;
  logic        st_vld_q [4];
  logic [31:0] st_k_q   [4];
  logic        st_adv   [4];

  always_comb begin
    k_seed   = head_i.start ? {{(32 - LenW){1'b0}}, head_i.seed} : key_q;
    k_mixed  = head_i.round ? mix_round(k_seed, head_i.word) : k_seed;
    ends_msg = head_i.finish || head_i.zero;

    st_adv[3] = !st_vld_q[3] || out_ready_i;
    st_adv[2] = !st_vld_q[2] || st_adv[3];
    st_adv[1] = !st_vld_q[1] || st_adv[2];
    st_adv[0] = !st_vld_q[0] || st_adv[1];
    fin_adv   = !fin_vld_q   || st_adv[0];

    pop_o = head_valid_i && (!ends_msg || fin_adv);
    key_d = key_q;
    if (pop_o) begin
      key_d = ends_msg ? 32'd0 : k_mixed;
    end

    out_valid_o = st_vld_q[3];
    hash_key_o  = st_k_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= 32'd0;
      fin_vld_q <= 1'b0;
      st_vld_q  <= '{default: 1'b0};
    end else begin
      key_q <= key_d;
      if (fin_adv) begin
        fin_vld_q <= pop_o && ends_msg;
      end
      if (st_adv[0]) st_vld_q[0] <= fin_vld_q;
      if (st_adv[1]) st_vld_q[1] <= st_vld_q[0];
      if (st_adv[2]) st_vld_q[2] <= st_vld_q[1];
      if (st_adv[3]) st_vld_q[3] <= st_vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_adv) begin
      fin_k_q    <= head_i.zero ? 32'd0 : k_mixed;
      fin_cnt_q  <= head_i.zero ? 2'd0  : head_i.tail_cnt;
      fin_tail_q <= head_i.tail;
    end
    if (st_adv[0]) st_k_q[0] <= tail_mix(fin_k_q, fin_cnt_q, fin_tail_q);
    if (st_adv[1]) st_k_q[1] <= aval_a(st_k_q[0]);
    if (st_adv[2]) st_k_q[2] <= aval_b(st_k_q[1]);
    if (st_adv[3]) st_k_q[3] <= aval_c(st_k_q[2]);
  end

endmodule

/* rtl/core/byte_stream_superfast_hash.sv */
// Top level of the byte-stream SuperFastHash block: front end, work queue and key datapath.
`timescale 1ns / 1ps

// Usage. Message bytes arrive one per transaction on the input channel (in_valid_i /
// in_ready_o), each with data_byte_i, message_length_i and last_byte_i. The length is
// sampled on the first byte of a message and seeds the key; the transaction flagged
// last_byte_i closes the message. A first byte whose length is zero is a message of its
// own that yields key zero. Each message produces one transaction on the output channel
// (out_valid_o, hash_key_o, with out_ready_i from the receiver).
// Throughput is one byte per cycle while the work queue has room. Once the last byte
// is accepted, its work item is written into the queue and then loaded into the
// datapath's pre-tail key register; four more register stages follow, one for the tail
// fold and three for the avalanche, the last of them holding the key. The front end only
// emits work for the first byte, every fourth byte and the last byte of a message.
// When the receiver stalls, the finishing stages fill, then the two-entry queue, and only
// then does in_ready_o fall; bytes that need no datapath work are still taken while the
// queue has room. Reset clears the front end state, the queue and all stage valid bits;
// the block then awaits the first byte of a new message.
module byte_stream_superfast_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] message_length_i,
  input  logic        last_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [31:0] hash_key_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import sfh_pkg::*;

  logic       q_ready;
  logic       job_push;
  logic       job_pop;
  sfh_job_t   job_in;
  sfh_job_t   job_head;
  sfh_qstat_t q_stat;

  // Byte gathering and work-item generation.
  sfh_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .message_length_i (message_length_i),
    .last_byte_i      (last_byte_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .q_ready_i        (q_ready),
    .push_o           (job_push),
    .job_o            (job_in)
  );

  // The queue lets the front end keep taking bytes while the datapath waits on the output.
  sfh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .ready_o (q_ready),
    .pop_i   (job_pop),
    .head_o  (job_head),
    .stat_o  (q_stat)
  );

  // Running key, rounds, tail and avalanche; its last stage is the output register.
  sfh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (job_head),
    .head_valid_i (!q_stat.empty),
    .pop_o        (job_pop),
    .hash_key_o   (hash_key_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  // The queue cannot be both full and empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_stat.full && q_stat.empty))
    else $error("work queue reports full and empty together");

  // A work item is never written into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !q_stat.full)
    else $error("work item pushed into a full queue");

  // The datapath only takes an item that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> !q_stat.empty)
    else $error("work item popped from an empty queue");

endmodule

/* sim/tb_byte_stream_superfast_hash.sv */
// Self-checking testbench for the byte-stream SuperFastHash block.
`timescale 1ns / 1ps

module tb_byte_stream_superfast_hash;

  // One byte transaction as the sender presents it.
  typedef struct {
    logic [7:0]  data;
    logic [15:0] msg_len;
    logic        last;
  } hash_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  data_byte_i;
  logic [15:0] message_length_i;
  logic        last_byte_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] hash_key_o;
  logic        out_valid_o;
  logic        out_ready_i;

  byte_stream_superfast_hash dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .message_length_i (message_length_i),
    .last_byte_i      (last_byte_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .hash_key_o       (hash_key_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i)
  );

  // Bytes waiting to be offered, and keys the block still owes us.
  hash_byte_t  byte_backlog[$];
  logic [31:0] key_fifo[$];

  // Our own copy of the hash state, advanced on every accepted byte.
  bit [31:0] acc_key;
  bit [23:0] gathered;
  bit [1:0]  gathered_cnt;
  bit        msg_open;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned fail_count;
  bit          byte_taken;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A hung handshake must not hold the run forever.
  initial begin
    #2400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Advances the predicted state by one accepted byte. When the byte closes a
  // message (or is a zero-length message on its own) the finished key is returned.
  task automatic hash_byte(input hash_byte_t b, output bit has_key, output bit [31:0] key);
    bit [31:0] k;
    bit [31:0] hi;
    bit [31:0] t;
    has_key = 1'b0;
    key     = '0;
    if (!msg_open) begin
      // A zero length on a first byte is a whole message: its key is zero and the
      // byte itself and its last flag count for nothing.
      if (b.msg_len == 16'h0000) begin
        has_key = 1'b1;
        return;
      end
      acc_key      = {16'h0000, b.msg_len};
      gathered     = '0;
      gathered_cnt = '0;
      msg_open     = 1'b1;
    end

    k = acc_key;
    if (gathered_cnt == 2'd3) begin
      // Fourth byte of a group: one mixing round over the two 16-bit halves.
      hi = {16'h0000, b.data, gathered[23:16]};
      k  = k + {16'h0000, gathered[15:0]};
      t  = (hi << 11) ^ k;
      k  = (k << 16) ^ t;
      k  = k + (k >> 11);
      gathered     = '0;
      gathered_cnt = '0;
    end else begin
      gathered     = gathered | ({16'h0000, b.data} << (8 * gathered_cnt));
      gathered_cnt = gathered_cnt + 2'd1;
    end

    if (!b.last) begin
      acc_key = k;
      return;
    end

    // The tail size follows the bytes actually seen, whatever length was sampled.
    // Lone tail bytes are sign-extended; the 16-bit halves never are.
    case (gathered_cnt)
      2'd3: begin
        k = k + {16'h0000, gathered[15:0]};
        k = k ^ (k << 16);
        k = k ^ ({{24{gathered[23]}}, gathered[23:16]} << 18);
        k = k + (k >> 11);
      end
      2'd2: begin
        k = k + {16'h0000, gathered[15:0]};
        k = k ^ (k << 11);
        k = k + (k >> 17);
      end
      2'd1: begin
        k = k + {{24{gathered[7]}}, gathered[7:0]};
        k = k ^ (k << 10);
        k = k + (k >> 1);
      end
      default: begin
      end
    endcase

    // Final avalanche.
    k = k ^ (k << 3);
    k = k + (k >> 5);
    k = k ^ (k << 4);
    k = k + (k >> 17);
    k = k ^ (k << 25);
    k = k + (k >> 6);

    has_key      = 1'b1;
    key          = k;
    acc_key      = '0;
    gathered     = '0;
    gathered_cnt = '0;
    msg_open     = 1'b0;
  endtask

  function automatic void add_byte(input logic [7:0] data, input logic [15:0] msg_len,
                                   input logic last);
    hash_byte_t b;
    b.data    = data;
    b.msg_len = msg_len;
    b.last    = last;
    byte_backlog.push_back(b);
  endfunction

  // Queues one random message and returns how many transactions it took. Most
  // messages carry their true length; some carry a random or maximal length,
  // and some are zero-length messages. Bytes after the first carry junk in the
  // length field, which the block must ignore.
  function automatic int queue_random_message();
    int          nbytes;
    int unsigned pick;
    logic [15:0] seed_len;
    pick   = $urandom_range(99);
    nbytes = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    if (pick < 10) begin
      add_byte(8'($urandom), 16'h0000, 1'($urandom));
      return 1;
    end else if (pick < 75) begin
      seed_len = 16'(nbytes);
    end else if (pick < 80) begin
      seed_len = 16'hFFFF;
    end else begin
      seed_len = 16'($urandom_range(1, 65535));
    end
    for (int i = 0; i < nbytes; i++) begin
      add_byte(8'($urandom), (i == 0) ? seed_len : 16'($urandom), i == nbytes - 1);
    end
    return nbytes;
  endfunction

  // Sender: offers a new byte at the falling edge once the previous one has gone.
  // The backlog is only popped here, so valid and the payload hold while waiting.
  always @(negedge clk_i) begin
    hash_byte_t b;
    if (rst_ni) begin
      if (!in_valid_i || byte_taken) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          b = byte_backlog.pop_front();
          data_byte_i      <= b.data;
          message_length_i <= b.msg_len;
          last_byte_i      <= b.last;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: every transaction is taken at the rising edge. The input is
  // predicted before the output is checked, so a key could never be compared
  // before its message was seen.
  always @(posedge clk_i) begin
    hash_byte_t b;
    bit         has_key;
    bit [31:0]  key;
    byte_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        byte_taken = 1'b1;
        b.data     = data_byte_i;
        b.msg_len  = message_length_i;
        b.last     = last_byte_i;
        hash_byte(b, has_key, key);
        if (has_key) key_fifo.push_back(key);
      end
      if (out_valid_o && out_ready_i) begin
        if (key_fifo.size() == 0) begin
          $error("hash_key: unexpected result 0x%08h with nothing outstanding", hash_key_o);
          fail_count++;
        end else begin
          key = key_fifo.pop_front();
          if (hash_key_o !== key) begin
            $error("hash_key: expected 0x%08h, got 0x%08h", key, hash_key_o);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int queued;
    data_byte_i        = '0;
    message_length_i   = '0;
    last_byte_i        = 1'b0;
    in_valid_i         = 1'b0;
    out_ready_i        = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fail_count         = 0;
    acc_key            = '0;
    gathered           = '0;
    gathered_cnt       = '0;
    msg_open           = 1'b0;
    rst_ni             = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed messages. Zero-length messages, with and without the last flag,
    // whose data byte must be ignored.
    add_byte(8'hFF, 16'h0000, 1'b1);
    add_byte(8'h5A, 16'h0000, 1'b0);
    // Single-byte tails either side of the sign boundary.
    add_byte(8'h80, 16'h0001, 1'b1);
    add_byte(8'h7F, 16'h0001, 1'b1);
    // Two-byte tail of all ones, then a three-byte tail with a negative top byte.
    add_byte(8'hFF, 16'h0002, 1'b0);
    add_byte(8'hFF, 16'hFFFF, 1'b1);
    add_byte(8'h00, 16'h0003, 1'b0);
    add_byte(8'h00, 16'h0000, 1'b0);
    add_byte(8'h80, 16'h0000, 1'b1);
    // One full group and no tail, seeded with the largest length.
    for (int i = 0; i < 4; i++) add_byte(8'hFF, 16'hFFFF, i == 3);
    // A round followed by a one-byte tail.
    for (int i = 0; i < 5; i++) add_byte(8'hA5 ^ 8'(i), 16'h0005, i == 4);
    // The sampled length disagrees with the bytes actually sent.
    for (int i = 0; i < 6; i++) add_byte(8'(i * 51), (i == 0) ? 16'h0001 : 16'h0000, i == 5);

    // Four phases: free running, a lazy sender, a stalling receiver, then both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
        default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
      endcase
      queued = 0;
      while (queued < 375) queued += queue_random_message();
      while (byte_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
      // Let the block drain completely before the next phase starts.
      while (key_fifo.size() != 0) @(posedge clk_i);
    end

    // A few quiet cycles to catch any stray key after the last one.
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
